FILE: hw/rtl/itws_pkg.sv
// shared types, constants and mode limit table for the i2c timing word search
`default_nettype none

package itws_pkg;

    localparam int TW = 48;           // width of most nanosecond times in the datapath
    localparam int SRC_W = 30;
    localparam int TGT_W = 22;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam int PRESC_STEPS = 16;
    localparam int DELAY_STEPS = 16;
    localparam int PERIOD_STEPS = 256;
    localparam int TABLE_DEPTH = 16;

    localparam logic [SRC_W-1:0] NS_PER_S = 30'd1000000000;
    localparam logic [TW-1:0] AF_MIN_NS = 48'd50;
    localparam logic [TW-1:0] AF_MAX_NS = 48'd260;

    localparam logic [TGT_W-1:0] SM_MAX_HZ = 22'd100000;
    localparam logic [TGT_W-1:0] FM_MAX_HZ = 22'd400000;
    localparam logic [TGT_W-1:0] FMP_MAX_HZ = 22'd1000000;

    localparam logic [1:0] MODE_SM = 2'd0;
    localparam logic [1:0] MODE_FM = 2'd1;
    localparam logic [1:0] MODE_FMP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DNF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE = 2'd2;

    localparam logic [3:0] DNF_RESET = 4'd0;
    localparam logic [9:0] FALL_RESET = 10'd100;
    localparam logic [9:0] RISE_RESET = 10'd100;

    typedef struct packed {
        logic [31:0] nominal;
        logic [31:0] per_min;
        logic [31:0] per_max;
        logic [31:0] low_min;
        logic [31:0] high_min;
        logic [31:0] scl_min;
        logic [31:0] fall_max;
        logic [31:0] vd_max;
    } mode_lim_t;

    typedef struct packed {
        logic load;
        logic prep1;
        logic prep2;
        logic dly_init;
        logic dly_step;
        logic k_read;
        logic k_mul;
        logic k_init;
        logic lh_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic dly_done;
        logic k_done;
        logic lh_done;
    } stat_t;

    // periods are 1e9 / f truncated; scl_min is rise_max - su_min
    function automatic mode_lim_t mode_limits(input logic [1:0] mode);
        mode_lim_t m;
        case (mode)
            MODE_SM:  m = '{32'd10000, 32'd10000, 32'd1000000000, 32'd4700, 32'd4000,
                            32'd750, 32'd300, 32'd3450};
            MODE_FM:  m = '{32'd2500, 32'd2500, 32'd9999, 32'd1300, 32'd600,
                            32'd200, 32'd300, 32'd900};
            default:  m = '{32'd1000, 32'd1000, 32'd2499, 32'd500, 32'd260,
                            32'd70, 32'd120, 32'd450};
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/itws_div.sv
// restoring divider: 1e9 / kernel clock frequency, one quotient bit per cycle
`default_nettype none

module itws_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [itws_pkg::SRC_W-1:0] divisor,
    output logic      [itws_pkg::SRC_W-1:0] quotient,
    output logic                            done
);

    localparam int W = itws_pkg::SRC_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic run_reg, run_next;
    logic done_reg, done_next;
    logic [W:0] rem_shift;
    logic fits;

    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign fits = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next = itws_pkg::NS_PER_S;
            rem_next = '0;
            cnt_next = CNT_W'(W - 1);
            run_next = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/itws_dp.sv
// datapath: config registers, delay listing, period search and result register
`default_nettype none

module itws_dp #(
    parameter int PRESC_STEPS = itws_pkg::PRESC_STEPS,
    parameter int DELAY_STEPS = itws_pkg::DELAY_STEPS,
    parameter int PERIOD_STEPS = itws_pkg::PERIOD_STEPS,
    parameter int TABLE_DEPTH = itws_pkg::TABLE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire itws_pkg::cmd_t                  cmd,
    output itws_pkg::stat_t                      stat,
    input  wire logic [itws_pkg::SRC_W-1:0]      source_freq_hz,
    input  wire logic [itws_pkg::TGT_W-1:0]      target_freq_hz,
    input  wire logic                            cfg_we,
    input  wire logic [itws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [itws_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic      [itws_pkg::WORD_W-1:0]     timing_word,
    output logic                                 found
);

    localparam int TW = itws_pkg::TW;
    localparam int PW = (PRESC_STEPS > 1) ? $clog2(PRESC_STEPS) : 1;
    localparam int DW = (DELAY_STEPS > 1) ? $clog2(DELAY_STEPS) : 1;
    localparam int LW = (PERIOD_STEPS > 1) ? $clog2(PERIOD_STEPS) : 1;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [3:0] dnf_reg;
    logic [9:0] fall_reg;
    logic [9:0] rise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dnf_reg <= itws_pkg::DNF_RESET;
            fall_reg <= itws_pkg::FALL_RESET;
            rise_reg <= itws_pkg::RISE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                itws_pkg::CFG_DNF:  dnf_reg <= cfg_data[3:0];
                itws_pkg::CFG_FALL: fall_reg <= cfg_data;
                itws_pkg::CFG_RISE: rise_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request capture and mode select
    logic [1:0] mode_reg;
    logic skip_reg;
    itws_pkg::mode_lim_t ml;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
            mode_reg <= itws_pkg::MODE_SM;
        end
        else if (cmd.load)
        begin
            skip_reg <= (source_freq_hz == '0) || (target_freq_hz == '0)
                        || (target_freq_hz > itws_pkg::FMP_MAX_HZ);
            if (target_freq_hz <= itws_pkg::SM_MAX_HZ)
                mode_reg <= itws_pkg::MODE_SM;
            else if (target_freq_hz <= itws_pkg::FM_MAX_HZ)
                mode_reg <= itws_pkg::MODE_FM;
            else
                mode_reg <= itws_pkg::MODE_FMP;
        end
    end

    assign ml = itws_pkg::mode_limits(mode_reg);

    // kernel clock period
    logic [itws_pkg::SRC_W-1:0] tclk_q;
    logic div_done;
    logic [TW-1:0] tclk;

    itws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .divisor  (source_freq_hz),
        .quotient (tclk_q),
        .done     (div_done)
    );

    assign tclk = TW'(tclk_q);

    // per-request constants
    logic [TW-1:0] dnfd_reg, tclk3_reg, sda_min_reg, sda_max_reg, base_reg, ebase_reg;
    logic [TW-1:0] lo_sub, hi_sub, fall_max_w, vd_max_w;

    assign lo_sub = itws_pkg::AF_MIN_NS + dnfd_reg + tclk3_reg;
    assign hi_sub = itws_pkg::AF_MAX_NS + dnfd_reg + tclk3_reg + tclk;
    assign fall_max_w = TW'(ml.fall_max);
    assign vd_max_w = TW'(ml.vd_max);

    always_ff @(posedge clk)
    begin
        if (cmd.prep1)
        begin
            dnfd_reg <= TW'(34'(dnf_reg) * 34'(tclk_q));
            tclk3_reg <= (tclk << 1) + tclk;
        end
        if (cmd.prep2)
        begin
            sda_min_reg <= (fall_max_w > lo_sub) ? (fall_max_w - lo_sub) : '0;
            sda_max_reg <= (vd_max_w > hi_sub) ? (vd_max_w - hi_sub) : '0;
            base_reg <= itws_pkg::AF_MIN_NS + dnfd_reg + (tclk << 1);
        end
        if (cmd.dly_init)
            ebase_reg <= TW'(fall_reg) + TW'(rise_reg) + base_reg;
    end

    // delay listing: one (prescaler, scldel, sdadel) point per cycle
    logic [11:0] cand_mem [TABLE_DEPTH];
    logic [PW-1:0] p_reg;
    logic [DW-1:0] c_reg, d_reg;
    logic [TW-1:0] step_reg, tscl_reg, tsda_reg, step_inc;
    logic [CW-1:0] count_reg;
    logic dly_done_reg;
    logic scl_ok, sda_ok, take, c_end, adv_p, dly_fin;
    logic p_last, c_last, d_last;

    assign p_last = p_reg == PW'(PRESC_STEPS - 1);
    assign c_last = c_reg == DW'(DELAY_STEPS - 1);
    assign d_last = d_reg == DW'(DELAY_STEPS - 1);
    assign scl_ok = tscl_reg >= TW'(ml.scl_min);
    assign sda_ok = (tsda_reg >= sda_min_reg) && (tsda_reg <= sda_max_reg);
    assign take = scl_ok && sda_ok;
    assign c_end = !scl_ok || (!sda_ok && d_last);
    assign adv_p = take || (c_end && c_last);
    assign dly_fin = adv_p && (p_last || (take && (count_reg + 1'b1 >= CW'(TABLE_DEPTH))));
    assign step_inc = step_reg + tclk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dly_done_reg <= 1'b0;
        end
        else if (cmd.dly_init)
        begin
            count_reg <= '0;
            dly_done_reg <= 1'b0;
        end
        else if (cmd.dly_step)
        begin
            if (take)
                count_reg <= count_reg + 1'b1;
            if (dly_fin)
                dly_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dly_init)
        begin
            p_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            step_reg <= tclk;
            tscl_reg <= tclk;
            tsda_reg <= tclk;
        end
        else if (cmd.dly_step && !dly_fin)
        begin
            if (adv_p)
            begin
                p_reg <= p_reg + 1'b1;
                c_reg <= '0;
                d_reg <= '0;
                step_reg <= step_inc;
                tscl_reg <= step_inc;
                tsda_reg <= tclk;
            end
            else if (c_end)
            begin
                c_reg <= c_reg + 1'b1;
                d_reg <= '0;
                tscl_reg <= tscl_reg + step_reg;
                tsda_reg <= tclk;
            end
            else
            begin
                d_reg <= d_reg + 1'b1;
                tsda_reg <= tsda_reg + step_reg;
            end
        end
    end

    // candidate table: presc, scldel, sdadel
    logic [CW-1:0] k_reg;
    logic [11:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dly_step && take)
            cand_mem[count_reg[AW-1:0]] <= {4'(p_reg), 4'(c_reg), 4'(d_reg)};
        if (cmd.k_read)
            rd_reg <= cand_mem[k_reg[AW-1:0]];
    end

    // period search: one (low, high) pair per cycle
    logic [LW-1:0] l_reg, h_reg;
    logic [TW-1:0] tpresc_reg, tlow_reg, lrel_reg, elow_reg, thigh_reg, hinit_reg;
    logic [TW-1:0] tper, err, nom_w;
    logic [31:0] best_err_reg;
    logic best_valid_reg, lh_done_reg;
    logic [27:0] best_reg;  // presc, scldel, sdadel, sclh, scll
    logic l_ok, h_ok, better, h_end, l_last, h_last;

    assign nom_w = TW'(ml.nominal);
    assign l_last = l_reg == LW'(PERIOD_STEPS - 1);
    assign h_last = h_reg == LW'(PERIOD_STEPS - 1);
    assign l_ok = (tlow_reg >= TW'(ml.low_min)) && (tclk < (lrel_reg >> 2));
    assign tper = elow_reg + thigh_reg;
    assign h_ok = (tper >= TW'(ml.per_min)) && (tper <= TW'(ml.per_max))
                  && (thigh_reg >= TW'(ml.high_min)) && (tclk < thigh_reg);
    assign err = (tper >= nom_w) ? (tper - nom_w) : (nom_w - tper);
    assign better = l_ok && h_ok && (err < TW'(best_err_reg));
    assign h_end = !l_ok || h_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            lh_done_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                best_valid_reg <= 1'b0;
            if (cmd.dly_init)
                k_reg <= '0;
            if (cmd.k_init)
                lh_done_reg <= 1'b0;
            if (cmd.lh_step)
            begin
                if (better)
                    best_valid_reg <= 1'b1;
                if (h_end && l_last)
                begin
                    lh_done_reg <= 1'b1;
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dly_init)
            best_err_reg <= ml.nominal;
        if (cmd.k_mul)
            tpresc_reg <= TW'(35'(rd_reg[11:8] + 5'd1) * 35'(tclk_q));
        if (cmd.k_init)
        begin
            l_reg <= '0;
            h_reg <= '0;
            tlow_reg <= base_reg + tpresc_reg;
            lrel_reg <= (tclk << 1) + tpresc_reg;
            elow_reg <= ebase_reg + tpresc_reg;
            thigh_reg <= base_reg + tpresc_reg;
            hinit_reg <= base_reg + tpresc_reg;
        end
        else if (cmd.lh_step)
        begin
            if (better)
            begin
                best_err_reg <= err[31:0];
                best_reg <= {rd_reg[11:8], rd_reg[7:4], rd_reg[3:0], 8'(h_reg), 8'(l_reg)};
            end
            if (h_end)
            begin
                l_reg <= l_reg + 1'b1;
                h_reg <= '0;
                tlow_reg <= tlow_reg + tpresc_reg;
                lrel_reg <= lrel_reg + tpresc_reg;
                elow_reg <= elow_reg + tpresc_reg;
                thigh_reg <= hinit_reg;
            end
            else
            begin
                h_reg <= h_reg + 1'b1;
                thigh_reg <= thigh_reg + tpresc_reg;
            end
        end
    end

    // result register
    logic [itws_pkg::WORD_W-1:0] word_reg;
    logic found_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg <= best_valid_reg;
            word_reg <= best_valid_reg ? {best_reg[27:24], 4'd0, best_reg[23:0]} : '0;
        end
    end

    assign timing_word = word_reg;
    assign found = found_reg;

    assign stat.skip = skip_reg;
    assign stat.div_done = div_done;
    assign stat.dly_done = dly_done_reg;
    assign stat.k_done = k_reg == count_reg;
    assign stat.lh_done = lh_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("candidate count beyond table depth");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lh_step && better |=> best_valid_reg && (best_err_reg <= ml.nominal))
        else $error("best error above nominal period");

    a_k_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.k_read |-> k_reg < count_reg)
        else $error("candidate read beyond listed entries");

endmodule

`default_nettype wire

FILE: hw/rtl/itws_ctrl.sv
// controller: sequences divide, delay listing, period search and result handoff
`default_nettype none

module itws_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output itws_pkg::cmd_t       cmd,
    input  wire itws_pkg::stat_t stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_PREP1 = 4'd2;
    localparam logic [3:0] S_PREP2 = 4'd3;
    localparam logic [3:0] S_DINIT = 4'd4;
    localparam logic [3:0] S_DLY   = 4'd5;
    localparam logic [3:0] S_KRD   = 4'd6;
    localparam logic [3:0] S_KMUL  = 4'd7;
    localparam logic [3:0] S_KINIT = 4'd8;
    localparam logic [3:0] S_LH    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.skip)
                    state_next = S_OUT;
                else if (stat.div_done)
                    state_next = S_PREP1;
            end
            S_PREP1:
            begin
                cmd.prep1 = 1'b1;
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                cmd.prep2 = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.dly_init = 1'b1;
                state_next = S_DLY;
            end
            S_DLY:
            begin
                if (stat.dly_done)
                    state_next = S_KRD;
                else
                    cmd.dly_step = 1'b1;
            end
            S_KRD:
            begin
                if (stat.k_done)
                    state_next = S_OUT;
                else
                begin
                    cmd.k_read = 1'b1;
                    state_next = S_KMUL;
                end
            end
            S_KMUL:
            begin
                cmd.k_mul = 1'b1;
                state_next = S_KINIT;
            end
            S_KINIT:
            begin
                cmd.k_init = 1'b1;
                state_next = S_LH;
            end
            S_LH:
            begin
                if (stat.lh_done)
                    state_next = S_KRD;
                else
                    cmd.lh_step = 1'b1;
            end
            S_OUT:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    a_load_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded without valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.dly_step, cmd.lh_step, cmd.k_read, cmd.load}) <= 1)
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_timing_word_search_unit.sv
// top level of the i2c timing word search unit
`default_nettype none

// One request (kernel clock and bus clock in hertz) yields one result: the packed
// timing word and a found flag. Requests are handled one at a time; the block
// takes a new request once the previous one has been moved to the result
// register. A request runs the period divide, the setup steps, the delay listing
// and, for each listed prescaler, the low/high search, which checks one pair per
// cycle and dominates the run time. A zero or out-of-range frequency skips the
// search and returns found clear.
module i2c_timing_word_search_unit #(
    parameter int PRESC_STEPS = itws_pkg::PRESC_STEPS,
    parameter int DELAY_STEPS = itws_pkg::DELAY_STEPS,
    parameter int PERIOD_STEPS = itws_pkg::PERIOD_STEPS,
    parameter int TABLE_DEPTH = itws_pkg::TABLE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [55:0]                     s_axis_tdata,  // source_freq_hz, target_freq_hz
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [31:0]                     m_axis_tdata,  // timing_word
    output logic      [0:0]                      m_axis_tuser,  // found
    input  wire logic                            cfg_we,
    input  wire logic [itws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [itws_pkg::CFG_DATA_W-1:0] cfg_data
);

    itws_pkg::cmd_t cmd;
    itws_pkg::stat_t stat;
    logic found;

    itws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    itws_dp #(
        .PRESC_STEPS  (PRESC_STEPS),
        .DELAY_STEPS  (DELAY_STEPS),
        .PERIOD_STEPS (PERIOD_STEPS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .source_freq_hz (s_axis_tdata[29:0]),
        .target_freq_hz (s_axis_tdata[51:30]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .timing_word    (m_axis_tdata),
        .found          (found)
    );

    assign m_axis_tuser = found;

endmodule

`default_nettype wire
